// ----- rtl/acorr_pkg.sv -----
// acorr_pkg: shared types and fixed constants for the array autocorrelation unit
// no dependencies

package acorr_pkg;

   // fixed field widths of the ports
   localparam int SAMPLE_W = 16;
   localparam int LIMIT_W  = 7;
   localparam int LAG_W    = 6;
   localparam int COEF_W   = 32;

   // restoring divider: one integer bit and thirty fraction bits
   localparam int DIV_STEPS = 31;
   localparam int STEP_W    = 5;

   localparam logic signed [COEF_W-1:0] ONE_Q30 = 32'sd1073741824;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ACC  = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } acorr_state_type;

endpackage

// ----- rtl/array_autocorrelation_unit.sv -----
// array_autocorrelation_unit: normalized sample autocorrelation of one array
// depends on acorr_pkg
//
//   channel  | ports                                              | handshake
//   ---------+----------------------------------------------------+------------------------
//   request  | req_sample, req_lag_limit, req_last                | start high, busy low
//   response | rsp_lag_index, rsp_coefficient, rsp_undefined,     | rsp_strobe, one cycle,
//            | rsp_truncated, rsp_final_result                    | no back pressure
//
// a word without last is stored, or marks the array truncated once the store is full, and busy stays low.
// a word with last starts the lags, unless no lag is to be emitted; each lag
// runs through the single multiply-accumulate pipe and then the bit-serial
// divider, one lag after the other.
// reset clears the control state; the sample memory is never cleared,
// only entries written for the current array are read.
// the receiver cannot stall: each coefficient shows for one cycle.

module array_autocorrelation_unit
   import acorr_pkg::*;
#(
   parameter int MAX_LEN     = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [LIMIT_W-1:0]         req_lag_limit,
   input  logic                       req_last,
   output logic                       rsp_strobe,
   output logic [LAG_W-1:0]           rsp_lag_index,
   output logic signed [COEF_W-1:0]   rsp_coefficient,
   output logic                       rsp_undefined,
   output logic                       rsp_truncated,
   output logic                       rsp_final_result
);

   // widths derived from the store depth and the sample size
   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   // centred value n*x - S is a sum of n-1 sample differences
   localparam int D_W    = SAMPLE_BITS + ADDR_W + 1;
   localparam int P_W    = 2 * D_W;
   localparam int ACC_W  = 2 * D_W + ADDR_W;
   localparam int NX_W   = SAMPLE_BITS + CNT_W + 1;

   // sample memory, two registered read ports
   logic signed [SAMPLE_BITS-1:0] store_mem [MAX_LEN];
   logic signed [SAMPLE_BITS-1:0] rd_a_ff, rd_b_ff;

   acorr_state_type state_ff, state_in;

   // array bookkeeping
   logic [CNT_W-1:0]              count_ff, count_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] first_ff, first_in;
   logic                          same_ff, same_in;
   logic                          ovf_ff, ovf_in;
   logic [CNT_W-1:0]              lim_ff, lim_in;

   // lag loop and mac pipe
   logic [ADDR_W-1:0]             k_ff, k_in;
   logic [ADDR_W-1:0]             t_ff, t_in;
   logic                          issued_ff, issued_in;
   logic                          v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic signed [D_W-1:0]         d_a_ff, d_a_in, d_b_ff, d_b_in;
   logic signed [P_W-1:0]         prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic [ACC_W-1:0]              var_ff, var_in;

   // divider
   logic [ACC_W:0]                rem_ff, rem_in;
   logic [COEF_W-1:0]             q_ff, q_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic                          neg_ff, neg_in;

   // output word
   logic                          strobe_ff, strobe_in;
   logic [LAG_W-1:0]              lag_ff, lag_in;
   logic signed [COEF_W-1:0]      coef_ff, coef_in;
   logic                          undef_ff, undef_in;
   logic                          trunc_ff, trunc_in;
   logic                          final_ff, final_in;

   // combinational helpers
   logic                          accept;
   logic                          full;
   logic                          wr_en;
   logic signed [SAMPLE_BITS-1:0] x_new;
   logic [CNT_W-1:0]              cnt_new;
   logic [CNT_W-1:0]              lim_new;
   logic [ADDR_W-1:0]             addr_b;
   logic signed [NX_W-1:0]        nx_a, nx_b;
   logic [ACC_W-1:0]              mag;
   logic [ACC_W:0]                trial;
   logic                          qbit;
   logic                          round_up;
   logic [COEF_W-1:0]             q_rnd;
   logic                          undef_now;
   logic                          last_lag;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(MAX_LEN));
   assign x_new  = req_sample[SAMPLE_BITS-1:0];
   assign wr_en  = accept && !full;
   assign addr_b = t_ff + k_ff;

   // samples kept after this word, and lags to emit
   assign cnt_new = full ? count_ff : count_ff + CNT_W'(1);
   assign lim_new = (req_lag_limit > LIMIT_W'(cnt_new)) ? cnt_new : CNT_W'(req_lag_limit);

   // centred values: n*x - S
   assign nx_a = $signed({1'b0, count_ff}) * rd_a_ff;
   assign nx_b = $signed({1'b0, count_ff}) * rd_b_ff;

   assign mag       = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign trial     = (step_ff == '0) ? rem_ff : {rem_ff[ACC_W-1:0], 1'b0};
   assign qbit      = (trial >= {1'b0, var_ff});
   assign round_up  = ({rem_ff, 1'b0} >= {2'b00, var_ff});
   assign q_rnd     = q_ff + COEF_W'(round_up);
   assign undef_now = same_ff || (var_ff == '0);
   assign last_lag  = ((CNT_W'(k_ff) + CNT_W'(1)) == lim_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      first_in  = first_ff;
      same_in   = same_ff;
      ovf_in    = ovf_ff;
      lim_in    = lim_ff;
      k_in      = k_ff;
      t_in      = t_ff;
      issued_in = issued_ff;
      var_in    = var_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      step_in   = step_ff;
      neg_in    = neg_ff;
      strobe_in = 1'b0;
      lag_in    = lag_ff;
      coef_in   = coef_ff;
      undef_in  = undef_ff;
      trunc_in  = trunc_ff;
      final_in  = final_ff;

      // mac pipe: read, centre, multiply, accumulate
      v1_in   = (state_ff == ST_ACC) && !issued_ff;
      v2_in   = v1_ff;
      v3_in   = v2_ff;
      d_a_in  = D_W'(nx_a) - D_W'(sum_ff);
      d_b_in  = D_W'(nx_b) - D_W'(sum_ff);
      prod_in = d_a_ff * d_b_ff;
      acc_in  = v3_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!full) begin
                  count_in = count_ff + CNT_W'(1);
                  sum_in   = sum_ff + SUM_W'(x_new);
                  if (count_ff == '0) begin
                     first_in = x_new;
                  end else if (x_new != first_ff) begin
                     same_in = 1'b0;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  if (lim_new == '0) begin
                     // array ends with no coefficients
                     count_in = '0;
                     sum_in   = '0;
                     same_in  = 1'b1;
                     ovf_in   = 1'b0;
                  end else begin
                     lim_in    = lim_new;
                     k_in      = '0;
                     t_in      = '0;
                     issued_in = 1'b0;
                     acc_in    = '0;
                     state_in  = ST_ACC;
                  end
               end
            end
         end
         ST_ACC: begin
            if (!issued_ff) begin
               t_in = t_ff + ADDR_W'(1);
               if ((CNT_W'(t_ff) + CNT_W'(k_ff)) == (count_ff - CNT_W'(1))) begin
                  issued_in = 1'b1;
               end
            end else if (!v1_ff && !v2_ff && !v3_ff) begin
               // lag zero sum is the variance
               if (k_ff == '0) begin
                  var_in = ACC_W'(acc_ff);
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            neg_in   = acc_ff[ACC_W-1];
            rem_in   = {1'b0, (mag > var_ff) ? var_ff : mag};
            q_in     = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = qbit ? trial - {1'b0, var_ff} : trial;
            q_in    = {q_ff[COEF_W-2:0], qbit};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            strobe_in = 1'b1;
            lag_in    = LAG_W'(k_ff);
            undef_in  = undef_now;
            trunc_in  = ovf_ff;
            final_in  = last_lag;
            if (undef_now) begin
               coef_in = '0;
            end else if (q_rnd > COEF_W'(ONE_Q30)) begin
               coef_in = neg_ff ? -ONE_Q30 : ONE_Q30;
            end else begin
               coef_in = neg_ff ? -$signed(q_rnd) : $signed(q_rnd);
            end
            if (last_lag) begin
               count_in = '0;
               sum_in   = '0;
               same_in  = 1'b1;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end else begin
               k_in      = k_ff + ADDR_W'(1);
               t_in      = '0;
               issued_in = 1'b0;
               acc_in    = '0;
               state_in  = ST_ACC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sample memory: writes only while idle; the read ports run every cycle,
   // but their data is used only in the lag loop
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[count_ff[ADDR_W-1:0]] <= x_new;
      end
      rd_a_ff <= store_mem[t_ff];
      rd_b_ff <= store_mem[addr_b];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         sum_ff    <= '0;
         same_ff   <= 1'b1;
         ovf_ff    <= 1'b0;
         issued_ff <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         same_ff   <= same_in;
         ovf_ff    <= ovf_in;
         issued_ff <= issued_in;
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         v3_ff     <= v3_in;
         strobe_ff <= strobe_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      first_ff <= first_in;
      lim_ff   <= lim_in;
      k_ff     <= k_in;
      t_ff     <= t_in;
      d_a_ff   <= d_a_in;
      d_b_ff   <= d_b_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      var_ff   <= var_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      step_ff  <= step_in;
      neg_ff   <= neg_in;
      lag_ff   <= lag_in;
      coef_ff  <= coef_in;
      undef_ff <= undef_in;
      trunc_ff <= trunc_in;
      final_ff <= final_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_lag_index    = lag_ff;
   assign rsp_coefficient  = coef_ff;
   assign rsp_undefined    = undef_ff;
   assign rsp_truncated    = trunc_ff;
   assign rsp_final_result = final_ff;

`ifndef ASSERT_OFF
   // a coefficient only comes out of a running array
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("coefficient without a running array");

   // the last coefficient hands the unit back
   a_final_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_final_result |-> !busy)
      else $error("still busy after the final coefficient");

   // normalized result stays within plus and minus one
   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_coefficient <= ONE_Q30) && (rsp_coefficient >= -ONE_Q30))
      else $error("coefficient out of range");

   // zero variance gives a zero coefficient
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_undefined |-> (rsp_coefficient == '0))
      else $error("undefined coefficient not zero");
`endif

endmodule
